// ===== sv/shb_pkg.sv =====
// ============================================================================
// shb_pkg - shared types and constants for the string hash bucket block
// Hash width, multiplier, reset bucket count, controller state and command
// struct used by the controller and the datapath.
// ============================================================================
package shb_pkg;

	// Width of the running hash (16 to 64)
	localparam int HASH_BITS = 32;
	// Width of the division step counter
	localparam int CNT_W = (HASH_BITS > 1) ? $clog2(HASH_BITS) : 1;

	localparam int BYTE_W  = 8;
	localparam int BUCK_W  = 16;
	localparam int RAW_W   = 32;
	localparam int TDATA_W = RAW_W + BUCK_W;

	// Reset value of the bucket count register
	localparam logic [BUCK_W-1:0] NHASH = 16'd127;

	typedef logic [HASH_BITS-1:0] hash_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accum;    // transfer of a byte that is not the last one
		logic load;     // transfer of a last byte: close hash, start modulo
		logic step;     // advance the modulo by one bit
	} ctl_cmd_t;

	// Low 32 bits of the hash, zero-extended where the hash is narrower
	function automatic logic [RAW_W-1:0] raw_of(hash_t h);
		logic [63:0] w;
		w = 64'(h);
		return w[RAW_W-1:0];
	endfunction

	// One multiply-by-31 and add step: 31*h = 32*h - h
	function automatic hash_t hash_step(hash_t h, logic [BYTE_W-1:0] b);
		return HASH_BITS'((h << 5) - h + HASH_BITS'(b));
	endfunction

endpackage

// ===== sv/shb_ctrl.sv =====
// ============================================================================
// shb_ctrl - controller for the string hash bucket block
// Sequences string closure, the bit-serial modulo and the result transfer,
// and drives the stream handshakes.
// ============================================================================
module shb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output shb_pkg::ctl_cmd_t cmd
);

	shb_pkg::state_t state_q, state_d;
	logic [shb_pkg::CNT_W-1:0] cnt_q;
	logic fire_s;

	// Accept plain bytes at any time, a last byte only in idle, once the modulo is done and the result has left
	always_comb begin
		s_tready = !s_tlast || (state_q == shb_pkg::ST_IDLE);
		fire_s   = s_tvalid && s_tready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shb_pkg::ST_IDLE: begin
				if (fire_s && s_tlast) state_d = shb_pkg::ST_DIV;
			end
			shb_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = shb_pkg::ST_OUT;
			end
			shb_pkg::ST_OUT: begin
				if (m_tready) state_d = shb_pkg::ST_IDLE;
			end
			default: state_d = shb_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		m_tvalid  = 1'b0;
		cmd.accum = fire_s && !s_tlast;
		cmd.load  = 1'b0;
		cmd.step  = 1'b0;
		unique case (state_q)
			shb_pkg::ST_IDLE: cmd.load = fire_s && s_tlast;
			shb_pkg::ST_DIV:  cmd.step = 1'b1;
			shb_pkg::ST_OUT:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Division step counter: one step per hash bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= shb_pkg::CNT_W'(shb_pkg::HASH_BITS - 1);
		end else if (cmd.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== sv/shb_dpath.sv =====
// ============================================================================
// shb_dpath - datapath for the string hash bucket block
// Running hash accumulator, bucket count register and a restoring
// remainder unit that takes one hash bit per cycle.
// ============================================================================
module shb_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  shb_pkg::ctl_cmd_t                 cmd,
	input  logic [shb_pkg::BYTE_W-1:0]        byte_value,
	input  logic                              byte_valid,
	input  logic                              cfg_we,
	input  logic [shb_pkg::BUCK_W-1:0]        cfg_wdata,
	output logic [shb_pkg::TDATA_W-1:0]       result
);

	shb_pkg::hash_t hash_q, hash_next;
	shb_pkg::hash_t dvd_q;
	logic [shb_pkg::BUCK_W-1:0] bcount_q;
	logic [shb_pkg::BUCK_W-1:0] dsr_q;
	logic [shb_pkg::BUCK_W-1:0] rem_q;
	logic [shb_pkg::RAW_W-1:0]  raw_q;
	logic [shb_pkg::BUCK_W:0]   rem_sh;
	logic [shb_pkg::BUCK_W-1:0] bucket;

	// Fold in the byte if it belongs to the string
	always_comb begin
		hash_next = byte_valid ? shb_pkg::hash_step(hash_q, byte_value) : hash_q;
	end

	// Accumulate; clear on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (cmd.load) begin
			hash_q <= '0;
		end else if (cmd.accum) begin
			hash_q <= hash_next;
		end
	end

	// Bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= shb_pkg::NHASH;
		end else if (cfg_we) begin
			bcount_q <= cfg_wdata;
		end
	end

	// Shift in the next dividend bit
	always_comb begin
		rem_sh = {rem_q, dvd_q[shb_pkg::HASH_BITS-1]};
	end

	// Restoring remainder: compare and subtract once per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= hash_next;
			dsr_q <= bcount_q;
			rem_q <= '0;
			raw_q <= shb_pkg::raw_of(hash_next);
		end else if (cmd.step) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, dsr_q}) begin
				rem_q <= shb_pkg::BUCK_W'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[shb_pkg::BUCK_W-1:0];
			end
		end
	end

	// A zero bucket count gives bucket zero
	always_comb begin
		bucket = (dsr_q == '0) ? '0 : rem_q;
		result = {bucket, raw_q};
	end

endmodule

// ===== sv/string_hash_bucket.sv =====
// ============================================================================
// string_hash_bucket - multiplicative string hash with bucket index
// Hashes a string one byte per transfer (hash = 31*hash + byte) and gives
// the hash and the hash modulo a configurable bucket count per string.
// ============================================================================
// Bytes are taken one per cycle, but for a last byte while a result is pending.
// After its last byte is taken, the bit-serial remainder unit works through
// the hash (one hash bit per cycle); then the result is offered, and it can
// transfer as soon as it is offered. Bytes of the next string are taken
// meanwhile; its last byte waits until the result leaves.
// Reset (arst_n low, asynchronous) clears the hash and sets bucket count 127.
module string_hash_bucket (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // last_byte
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] raw_hash, [47:32] bucket_index
	// Bucket count register
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	shb_pkg::ctl_cmd_t cmd;

	shb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	shb_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.byte_value (s_tdata),
		.byte_valid (s_tuser),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.result     (m_tdata)
	);

endmodule

// ===== sv/shb_checker.sv =====
// ============================================================================
// shb_checker - port-level checks for string_hash_bucket
// Watches the stream ports for result holding and result sequencing.
// ============================================================================
module shb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One result per string: drop valid after the transfer
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result repeated");

	// No result is offered straight after a last byte: the remainder still runs
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !m_tvalid)
		else $error("result too early");

	// A last byte waits while a result is pending
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && s_tlast |-> !s_tready)
		else $error("last byte taken with result pending");

endmodule

bind string_hash_bucket shb_checker u_shb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/string_hash_bucket_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// string_hash_bucket_tb - self-checking bench for the string hash bucket
// Streams strings one byte per transfer and checks each hash and bucket
// index against a local model of the 31-multiplier hash. A short table of
// directed strings comes first, then random strings under several bucket
// counts, with random gaps and stalls on both streams.
// ============================================================================
module string_hash_bucket_tb;

	localparam int RESULT_LAT  = shb_pkg::HASH_BITS + 1;
	localparam int SETTLE      = RESULT_LAT + 8;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 125;

	typedef shb_pkg::hash_t hash_t;

	typedef struct packed {
		logic [31:0] raw;
		logic [15:0] bucket;
	} hash_res_t;

	typedef struct {
		logic [7:0] value;
		logic       valid;
		logic       last;
		logic       typed;   // res holds a hand-computed result
		hash_res_t  res;
	} string_row_t;

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        s_tvalid  = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata   = '0;
	logic                        s_tuser   = 1'b0;
	logic                        s_tlast   = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready  = 1'b0;
	logic [shb_pkg::TDATA_W-1:0] m_tdata;
	logic                        cfg_we    = 1'b0;
	logic [15:0]                 cfg_wdata = '0;

	// Model state: accumulator, bucket count and results still owed
	hash_t       acc_hash   = '0;
	logic [15:0] bucket_cnt = shb_pkg::NHASH;
	hash_res_t   hash_q[$];

	int errors       = 0;
	int results_seen = 0;
	int strings_sent = 0;
	int bytes_sent   = 0;
	int items_sent   = 0;
	int idle_cycles  = 0;
	int ready_hold   = 0;
	bit calm         = 1'b0;

	string_hash_bucket DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// Fold one accepted transfer into the hash; a last item closes the string
	function automatic void hash_fold(logic [7:0] value, logic valid, logic last);
		hash_t     h;
		hash_res_t r;
		h = acc_hash;
		if (valid)
			h = h * hash_t'(31) + hash_t'(value);
		if (!last) begin
			acc_hash = h;
			return;
		end
		r.raw    = 32'(h);
		r.bucket = (bucket_cnt != 0) ? 16'(h % hash_t'(bucket_cnt)) : '0;
		hash_q.push_back(r);
		acc_hash = '0;
	endfunction

	// Mostly back to back, some short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Offer one item, wait for its transfer, then maybe idle
	task automatic send_item(logic [7:0] value, logic valid, logic last,
			logic typed = 1'b0, hash_res_t res = '0);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= valid;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		hash_fold(value, valid, last);
		if (last && typed) begin
			void'(hash_q.pop_back());
			hash_q.push_back(res);
		end
		if (valid || last)
			items_sent++;
		if (valid)
			bytes_sent++;
		if (last)
			strings_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random string: random bytes with some zero bytes, ignored noise in between
	task automatic send_random_string();
		int         len;
		int         r;
		logic [7:0] value;
		calm = ($urandom_range(99) < 15);
		r = $urandom_range(99);
		len = (r < 70) ? $urandom_range(8) :
			(r < 95) ? $urandom_range(24, 9) : $urandom_range(60, 25);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 10)
				send_item(8'($urandom), 1'b0, 1'b0);
			value = ($urandom_range(99) < 6) ? 8'h00 : 8'($urandom);
			send_item(value, 1'b1, 1'b0);
		end
		send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
	endtask

	// Drain all results, let the back end settle, then write the bucket count
	task automatic set_buckets(logic [15:0] count);
		s_tvalid <= 1'b0;
		while (hash_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we    <= 1'b0;
		bucket_cnt = count;
	endtask

	// Result side: check each transfer, apply random back-pressure, watch for hangs
	always @(posedge clk) begin
		hash_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (hash_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], '0);
				end else begin
					want = hash_q.pop_front();
					if (m_tdata[31:0] !== want.raw)
						report_mismatch("raw_hash", m_tdata[31:0], want.raw);
					if (m_tdata[47:32] !== want.bucket)
						report_mismatch("bucket_index", 32'(m_tdata[47:32]),
							32'(want.bucket));
				end
			end

			if (ready_hold > 0) begin
				ready_hold--;
				m_tready <= 1'b0;
			end else if (calm || $urandom_range(99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				ready_hold = ($urandom_range(99) < 90) ? $urandom_range(3) :
					$urandom_range(40, 10);
				m_tready <= 1'b0;
			end

			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("string_hash_bucket_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		string_row_t rows[20];
		logic [15:0] settings[7];
		int          phase_end;

		// Directed strings at the reset bucket count of 127
		rows = '{
			// empty string: last item without a byte
			'{8'h00, 1'b0, 1'b1, 1'b1, {32'd0, 16'd0}},
			// single top byte: 255 mod 127 = 1
			'{8'hFF, 1'b1, 1'b1, 1'b1, {32'd255, 16'd1}},
			// single zero byte is hashed, not a terminator
			'{8'h00, 1'b1, 1'b1, 1'b1, {32'd0, 16'd0}},
			'{8'h01, 1'b1, 1'b1, 1'b1, {32'd1, 16'd1}},
			// ignored items around a zero byte in the middle of a string
			'{8'hAA, 1'b0, 1'b0, 1'b0, '0},
			'{8'h41, 1'b1, 1'b0, 1'b0, '0},
			'{8'h00, 1'b1, 1'b0, 1'b0, '0},
			'{8'h55, 1'b0, 1'b0, 1'b0, '0},
			'{8'h42, 1'b1, 1'b1, 1'b0, '0},
			// string closed by a last item without a byte
			'{8'h61, 1'b1, 1'b0, 1'b0, '0},
			'{8'h62, 1'b1, 1'b0, 1'b0, '0},
			'{8'h7F, 1'b0, 1'b1, 1'b0, '0},
			// run of top bytes to force wrap-around
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b1, 1'b0, '0}
		};
		// Bucket counts per random phase: the extremes, zero, and a few others
		settings = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(65535, 1)), 16'd2,
			16'($urandom_range(1000, 3)), 16'd31};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].value, rows[i].valid, rows[i].last, rows[i].typed, rows[i].res);

		foreach (settings[p]) begin
			set_buckets(settings[p]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_string();
		end

		// Drain and let the back end go quiet
		s_tvalid <= 1'b0;
		while (hash_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("hashed %0d strings from %0d bytes, %0d results checked",
			strings_sent, bytes_sent, results_seen);
		$display("bucket counts 127 (reset), 1, 65535, 0 and four more; %0d mismatches",
			errors);
		if (errors == 0)
			$display("string_hash_bucket_tb OK");
		else
			$display("string_hash_bucket_tb NOT OK");
		$finish;
	end

endmodule
